// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker file.
// Clock, and for AW_ASSERT the reset, are passed in so each use names its own sampling domain.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the asynchronous reset is low.
`define AW_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Assertion that is also checked while reset is applied.
`define AW_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// ===== src/pidaw_pkg.sv =====
// Package for the PID controller: Q-format widths, register codes, config bundle,
// saturating arithmetic helpers. No dependencies.
`timescale 1ns / 1ps

package pidaw_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int POLE_W     = 18;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int IDX_W      = 3;
	localparam int PIPE_DEPTH = 4;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [POLE_W-1:0] pole_t;

	localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam word_t WORD_ZERO = '0;

	typedef enum logic [IDX_W-1:0] {
		REG_KP    = IDX_W'(0),
		REG_KI    = IDX_W'(1),
		REG_KD    = IDX_W'(2),
		REG_POLE  = IDX_W'(3),
		REG_OMAX  = IDX_W'(4),
		REG_OMIN  = IDX_W'(5)
	} reg_idx_t;

	localparam word_t KP_RST   = 32'sd9830400;
	localparam word_t KI_RST   = 32'sd2457600;
	localparam word_t KD_RST   = 32'sd5242880;
	localparam pole_t POLE_RST = 18'sd39322;
	localparam word_t OMAX_RST = 32'sd65536000;
	localparam word_t OMIN_RST = -32'sd65536000;

	typedef struct packed {
		word_t kp;
		word_t ki;
		word_t kd;
		pole_t pole;
		word_t hi;
		word_t lo;
	} cfg_t;

	// Products leaving the multiply stage
	typedef struct packed {
		word_t prop;
		word_t iprod;
		word_t dprod;
	} terms_t;

	// Proportional term with the updated integrator and derivative states
	typedef struct packed {
		word_t prop;
		word_t integ;
		word_t deriv;
	} acc_t;

	function automatic word_t sat_add(word_t a, word_t b);
		logic [DATA_W:0] s;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1])
			return s[DATA_W] ? WORD_MIN : WORD_MAX;
		return word_t'(s[DATA_W-1:0]);
	endfunction

	function automatic word_t sat_sub(word_t a, word_t b);
		logic [DATA_W:0] s;
		s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1])
			return s[DATA_W] ? WORD_MIN : WORD_MAX;
		return word_t'(s[DATA_W-1:0]);
	endfunction

	function automatic word_t sat_neg(word_t a);
		if (a == WORD_MIN)
			return WORD_MAX;
		return -a;
	endfunction

	// Full product, floor shift by the fraction width, saturate to one word
	function automatic word_t q_mul(word_t a, word_t b);
		prod_t p;
		prod_t sh;
		logic [PROD_W-DATA_W:0] top;
		p = a * b;
		sh = p >>> FRAC_W;
		top = sh[PROD_W-1:DATA_W-1];
		if (top == '0 || top == '1)
			return word_t'(sh[DATA_W-1:0]);
		return sh[PROD_W-1] ? WORD_MIN : WORD_MAX;
	endfunction

	function automatic word_t pole_ext(pole_t p);
		return {{(DATA_W-POLE_W){p[POLE_W-1]}}, p};
	endfunction

endpackage

// ===== src/pidaw_regs.sv =====
// Configuration register file for the PID controller.
// Depends on pidaw_pkg for register codes, reset values and the cfg_t bundle.
`timescale 1ns / 1ps

module pidaw_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [pidaw_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pidaw_pkg::DATA_W-1:0] cfg_data,
	output pidaw_pkg::cfg_t              cfg
);

	pidaw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp   <= pidaw_pkg::KP_RST;
			cfg_q.ki   <= pidaw_pkg::KI_RST;
			cfg_q.kd   <= pidaw_pkg::KD_RST;
			cfg_q.pole <= pidaw_pkg::POLE_RST;
			cfg_q.hi   <= pidaw_pkg::OMAX_RST;
			cfg_q.lo   <= pidaw_pkg::OMIN_RST;
		end else if (cfg_wr_en) begin
			case (pidaw_pkg::reg_idx_t'(cfg_index))
				pidaw_pkg::REG_KP:   cfg_q.kp   <= pidaw_pkg::word_t'(cfg_data);
				pidaw_pkg::REG_KI:   cfg_q.ki   <= pidaw_pkg::word_t'(cfg_data);
				pidaw_pkg::REG_KD:   cfg_q.kd   <= pidaw_pkg::word_t'(cfg_data);
				pidaw_pkg::REG_POLE: cfg_q.pole <= pidaw_pkg::pole_t'(
					cfg_data[pidaw_pkg::POLE_W-1:0]);
				pidaw_pkg::REG_OMAX: cfg_q.hi   <= pidaw_pkg::word_t'(cfg_data);
				pidaw_pkg::REG_OMIN: cfg_q.lo   <= pidaw_pkg::word_t'(cfg_data);
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/pidaw_terms.sv =====
// Input register and multiply stage: error, error sum and measurement change,
// then the proportional, integral and derivative products. Uses pidaw_pkg.
`timescale 1ns / 1ps

module pidaw_terms (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pidaw_pkg::cfg_t       cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pidaw_pkg::word_t      target,
	input  pidaw_pkg::word_t      measurement,
	output logic                  dn_valid,
	input  logic                  dn_ready,
	output pidaw_pkg::terms_t     terms
);

	logic              v_s1;
	logic              v_s2;
	logic              adv_s1;
	logic              adv_s2;
	pidaw_pkg::word_t  prev_err_q;
	pidaw_pkg::word_t  prev_meas_q;
	pidaw_pkg::word_t  err;
	pidaw_pkg::word_t  err_s1;
	pidaw_pkg::word_t  esum_s1;
	pidaw_pkg::word_t  dmeas_s1;
	pidaw_pkg::terms_t terms_s2;

	assign adv_s2   = !v_s2 || dn_ready;
	assign in_ready = !v_s1 || adv_s2;
	assign adv_s1   = in_valid && in_ready;

	assign err = pidaw_pkg::sat_sub(target, measurement);

	// history advances at transfer time, so back-to-back items see it current
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			prev_err_q  <= pidaw_pkg::WORD_ZERO;
			prev_meas_q <= pidaw_pkg::WORD_ZERO;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (adv_s2)
				v_s2 <= v_s1;
			if (adv_s1) begin
				prev_err_q  <= err;
				prev_meas_q <= measurement;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			err_s1   <= err;
			esum_s1  <= pidaw_pkg::sat_add(err, prev_err_q);
			dmeas_s1 <= pidaw_pkg::sat_sub(measurement, prev_meas_q);
		end
		if (adv_s2 && v_s1) begin
			terms_s2.prop  <= pidaw_pkg::q_mul(cfg.kp, err_s1);
			terms_s2.iprod <= pidaw_pkg::q_mul(cfg.ki, esum_s1);
			terms_s2.dprod <= pidaw_pkg::q_mul(cfg.kd, dmeas_s1);
		end
	end

	assign dn_valid = v_s2;
	assign terms    = terms_s2;

endmodule

// ===== src/pidaw_state.sv =====
// State update stage: clamped trapezoidal integrator and filtered derivative.
// Holds integral and derivative state; uses pidaw_pkg arithmetic.
`timescale 1ns / 1ps

module pidaw_state (
	input  logic              clk,
	input  logic              arst_n,
	input  pidaw_pkg::cfg_t   cfg,
	input  logic              up_valid,
	output logic              up_ready,
	input  pidaw_pkg::terms_t terms,
	output logic              dn_valid,
	input  logic              dn_ready,
	output pidaw_pkg::acc_t   acc
);

	logic             v_s3;
	logic             adv;
	pidaw_pkg::word_t integ_q;
	pidaw_pkg::word_t deriv_q;
	pidaw_pkg::word_t prop_s3;
	pidaw_pkg::word_t hi_room;
	pidaw_pkg::word_t lo_room;
	pidaw_pkg::word_t integ_raw;
	pidaw_pkg::word_t integ_next;
	pidaw_pkg::word_t deriv_next;

	assign up_ready = !v_s3 || dn_ready;
	assign adv      = up_valid && up_ready;

	// room the proportional term leaves inside the output limits
	always_comb begin
		hi_room = (cfg.hi > terms.prop) ?
			pidaw_pkg::sat_sub(cfg.hi, terms.prop) : pidaw_pkg::WORD_ZERO;
		lo_room = (cfg.lo < terms.prop) ?
			pidaw_pkg::sat_sub(cfg.lo, terms.prop) : pidaw_pkg::WORD_ZERO;
		integ_raw = pidaw_pkg::sat_add(integ_q, terms.iprod);
		if (integ_raw > hi_room)
			integ_next = hi_room;
		else if (integ_raw < lo_room)
			integ_next = lo_room;
		else
			integ_next = integ_raw;
		deriv_next = pidaw_pkg::sat_neg(pidaw_pkg::sat_add(terms.dprod,
			pidaw_pkg::q_mul(pidaw_pkg::pole_ext(cfg.pole), deriv_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			integ_q <= pidaw_pkg::WORD_ZERO;
			deriv_q <= pidaw_pkg::WORD_ZERO;
		end else begin
			if (up_ready)
				v_s3 <= up_valid;
			if (adv) begin
				integ_q <= integ_next;
				deriv_q <= deriv_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			prop_s3 <= terms.prop;
	end

	assign dn_valid  = v_s3;
	assign acc.prop  = prop_s3;
	assign acc.integ = integ_q;
	assign acc.deriv = deriv_q;

endmodule

// ===== src/pidaw_out.sv =====
// Output stage: sum of the three terms, clamp to the output limits, result register.
// Uses pidaw_pkg arithmetic and the acc_t bundle.
`timescale 1ns / 1ps

module pidaw_out (
	input  logic             clk,
	input  logic             arst_n,
	input  pidaw_pkg::cfg_t  cfg,
	input  logic             up_valid,
	output logic             up_ready,
	input  pidaw_pkg::acc_t  acc,
	output logic             out_valid,
	input  logic             out_ready,
	output pidaw_pkg::word_t drive,
	output logic             saturated
);

	logic             v_q;
	logic             adv;
	pidaw_pkg::word_t sum;
	pidaw_pkg::word_t drive_d;
	logic             sat_d;
	pidaw_pkg::word_t drive_q;
	logic             sat_q;

	assign up_ready = !v_q || out_ready;
	assign adv      = up_valid && up_ready;

	// when the limits are crossed, the upper limit wins for a sum above it, else the lower
	always_comb begin
		sum = pidaw_pkg::sat_add(pidaw_pkg::sat_add(acc.prop, acc.integ), acc.deriv);
		drive_d = sum;
		sat_d   = 1'b0;
		if (sum > cfg.hi) begin
			drive_d = cfg.hi;
			sat_d   = 1'b1;
		end else if (sum < cfg.lo) begin
			drive_d = cfg.lo;
			sat_d   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_q <= drive_d;
			sat_q   <= sat_d;
		end
	end

	assign out_valid = v_q;
	assign drive     = drive_q;
	assign saturated = sat_q;

endmodule

// ===== src/pid_controller_antiwindup.sv =====
// Top level of the PID controller with integrator clamp and filtered derivative.
// Instantiates pidaw_regs, pidaw_terms, pidaw_state and pidaw_out; uses pidaw_pkg.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   input    | in_valid / in_ready   | target, measurement (Q16.16)
//   output   | out_valid / out_ready | drive (Q16.16), saturated
//   config   | cfg_wr_en             | cfg_index, cfg_data
//
// One item per cycle while out_ready holds; out_valid rises after the input,
// multiply, state and result registers. The pole multiply feeding the derivative
// state and integrator clamp close their loops in the state stage at that rate.
// Reset clears valid bits, integrator, derivative and history to zero and loads
// the register defaults. A stalled output backs up the stages one by one.
`timescale 1ns / 1ps

module pid_controller_antiwindup (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [pidaw_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pidaw_pkg::DATA_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  pidaw_pkg::word_t             target,
	input  pidaw_pkg::word_t             measurement,
	output logic                         out_valid,
	input  logic                         out_ready,
	output pidaw_pkg::word_t             drive,
	output logic                         saturated
);

	pidaw_pkg::cfg_t   cfg;
	pidaw_pkg::terms_t terms;
	pidaw_pkg::acc_t   acc;
	logic              terms_valid;
	logic              terms_ready;
	logic              acc_valid;
	logic              acc_ready;

	pidaw_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidaw_terms u_terms (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.target      (target),
		.measurement (measurement),
		.dn_valid    (terms_valid),
		.dn_ready    (terms_ready),
		.terms       (terms)
	);

	pidaw_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (terms_valid),
		.up_ready (terms_ready),
		.terms    (terms),
		.dn_valid (acc_valid),
		.dn_ready (acc_ready),
		.acc      (acc)
	);

	pidaw_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.up_valid  (acc_valid),
		.up_ready  (acc_ready),
		.acc       (acc),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive),
		.saturated (saturated)
	);

endmodule

// ===== src/pidaw_checker.sv =====
// Port-level checker for the PID controller, bound to the top level.
// Depends on pidaw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pidaw_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [pidaw_pkg::DATA_W-1:0] drive,
	input logic                    saturated
);

	localparam int CNT_W = $clog2(pidaw_pkg::PIPE_DEPTH + 1);

	logic             in_xfer;
	logic             out_xfer;
	logic [CNT_W-1:0] cnt_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// items in flight, seen from the ports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({in_xfer, out_xfer})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// reset seen at an edge clears the output valid bit by the next edge
	`AW_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |=> !out_valid, "out_valid after reset")
	`AW_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(saturated), "stalled result changed")
	`AW_ASSERT(a_backpressure, clk, arst_n, !in_ready |-> out_valid && !out_ready, "input stalled without output stall")
	`AW_ASSERT(a_no_phantom, clk, arst_n, out_valid |-> cnt_q != '0, "result without accepted item")
	`AW_ASSERT(a_depth, clk, arst_n, cnt_q <= CNT_W'(pidaw_pkg::PIPE_DEPTH), "more items in flight than stages")

endmodule

bind pid_controller_antiwindup pidaw_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.drive     (drive),
	.saturated (saturated)
);
